// File: hw/rtl/tsc_pkg.sv
// Shared constants and widths for the Taylor sine/cosine core.
`default_nettype none
package tsc_pkg;
	localparam int ANGLE_W = 17;
	localparam int RAD_W = 35;
	// pi/180 in Q40, rounded
	localparam logic [RAD_W-1:0] RAD_PER_DEG_Q40 = 35'd19190098069;
	// angle LSB is 2^-7 degree, constant is Q40
	localparam int RAD_SHIFT_BASE = 47;
	// growth margins above the fraction bits (|x| < 16, x^2 < 128,
	// term < 2048, sum < 8192 for any 17-bit angle)
	localparam int XM_EXTRA = 4;
	localparam int XW_EXTRA = 7;
	localparam int TW_EXTRA = 12;
	localparam int PW_EXTRA = 19;
	localparam int SW_EXTRA = 17;
	localparam int TERMS_W = 4;
	localparam logic [TERMS_W-1:0] NUM_TERMS_RST = 4'd4;
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;
	localparam int REG_NUM_TERMS = 0;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 64;
	localparam int OUT_W = 32;
	localparam longint SAT_HI_L = 64'sh0000_0000_7fff_ffff;
	localparam longint SAT_LO_L = -64'sh0000_0000_8000_0000;
endpackage
`default_nettype wire

// File: hw/rtl/tsc_term.sv
// One series term lane: term update by x^2 and a constant divisor, then accumulate.
`default_nettype none
module tsc_term #(
	parameter int FRAC_BITS = 24,
	parameter int DIV = 2,
	localparam int TW = FRAC_BITS + tsc_pkg::TW_EXTRA,
	localparam int XW = FRAC_BITS + tsc_pkg::XW_EXTRA,
	localparam int SW = FRAC_BITS + tsc_pkg::SW_EXTRA
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [TW-1:0]        in_term,
	input  wire logic signed [SW-1:0] in_sum,
	input  wire logic [XW-1:0]        x2,
	input  wire logic                 use_term,
	input  wire logic                 sub_term,
	output logic [TW-1:0]             out_term,
	output logic signed [SW-1:0]      out_sum
);
	import tsc_pkg::*;

	localparam int PW = FRAC_BITS + PW_EXTRA;
	localparam int HL = TW / 2;
	localparam int HH = TW - HL;
	localparam int PH = PW / 2;
	localparam int PHH = PW - PH;
	localparam int LOW = HL + XW;
	localparam int HIW = HH + XW;
	localparam int FW = TW + XW;
	localparam int RW = 2 * PW + 2;
	localparam logic [PW-1:0] RECIP = PW'((64'd1 << PW) / DIV);
	localparam logic [PW-1:0] DIV_P = PW'(DIV);

	logic [LOW-1:0] pp_lo_s1;
	logic [HIW-1:0] pp_hi_s1;
	logic [PW-1:0] p_s2, p_s3, p_s4;
	logic [2*PH-1:0] r_ll_s3;
	logic [PW-1:0] r_lh_s3, r_hl_s3;
	logic [2*PHH-1:0] r_hh_s3;
	logic [TW-1:0] q0_s4, term_s5, term_s6;
	logic signed [SW-1:0] sum_s1, sum_s2, sum_s3, sum_s4, sum_s5, sum_s6;
	logic [4:0] use_d, sub_d;
	logic [FW-1:0] full_c;
	logic [RW-1:0] prod_c;
	logic [PW-1:0] rem_c;
	logic signed [SW-1:0] tx_c;

	assign full_c = (FW'(pp_hi_s1) << HL) + FW'(pp_lo_s1);
	assign prod_c = RW'(r_ll_s3) + (RW'(r_lh_s3) << PH) + (RW'(r_hl_s3) << PH)
		+ (RW'(r_hh_s3) << (2 * PH));
	assign rem_c = p_s4 - PW'(q0_s4) * DIV_P;
	assign tx_c = signed'(SW'(term_s5));

	always_ff @(posedge clk) begin
		if (en) begin
			pp_lo_s1 <= LOW'(in_term[HL-1:0]) * LOW'(x2);
			pp_hi_s1 <= HIW'(in_term[TW-1:HL]) * HIW'(x2);
			sum_s1 <= in_sum;
			use_d <= {use_d[3:0], use_term};
			sub_d <= {sub_d[3:0], sub_term};
			p_s2 <= full_c[FW-1:FRAC_BITS];
			sum_s2 <= sum_s1;
			r_ll_s3 <= (2*PH)'(p_s2[PH-1:0]) * (2*PH)'(RECIP[PH-1:0]);
			r_lh_s3 <= PW'(p_s2[PH-1:0]) * PW'(RECIP[PW-1:PH]);
			r_hl_s3 <= PW'(p_s2[PW-1:PH]) * PW'(RECIP[PH-1:0]);
			r_hh_s3 <= (2*PHH)'(p_s2[PW-1:PH]) * (2*PHH)'(RECIP[PW-1:PH]);
			p_s3 <= p_s2;
			sum_s3 <= sum_s2;
			q0_s4 <= TW'(prod_c >> PW);
			p_s4 <= p_s3;
			sum_s4 <= sum_s3;
			// reciprocal estimate is low by at most one
			term_s5 <= (rem_c >= DIV_P) ? q0_s4 + TW'(1) : q0_s4;
			sum_s5 <= sum_s4;
			term_s6 <= term_s5;
			if (!use_d[4]) begin
				sum_s6 <= sum_s5;
			end else if (sub_d[4]) begin
				sum_s6 <= sum_s5 - tx_c;
			end else begin
				sum_s6 <= sum_s5 + tx_c;
			end
		end
	end

	assign out_term = term_s6;
	assign out_sum = sum_s6;
endmodule
`default_nettype wire

// File: hw/rtl/taylor_sine_cosine_core.sv
// Taylor sine/cosine core. Throughput: one transaction per cycle while the output
// is not held; every term is its own six-stage section (two partial products,
// reciprocal multiply for the constant divide, correction, add).
// The whole pipeline advances together and holds when the output register is full
// and not taken. Reset clears valid bits and sets num_terms to 4; data registers
// are not reset.
`default_nettype none
module taylor_sine_cosine_core #(
	parameter int MAX_TERMS = 8,
	parameter int FRAC_BITS = 24
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [tsc_pkg::APB_AW-1:0]     paddr,
	input  wire logic [tsc_pkg::APB_DW-1:0]     pwdata,
	output logic [tsc_pkg::APB_DW-1:0]          prdata,
	output logic                                pready,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [tsc_pkg::S_TDATA_W-1:0]  s_tdata,  // angle_deg[16:0], zero pad
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [tsc_pkg::M_TDATA_W-1:0]       m_tdata,  // sine_value, cosine_value
	output logic [0:0]                          m_tuser   // clipped
);
	import tsc_pkg::*;

	localparam int XMW = FRAC_BITS + XM_EXTRA;
	localparam int XW = FRAC_BITS + XW_EXTRA;
	localparam int TW = FRAC_BITS + TW_EXTRA;
	localparam int SW = FRAC_BITS + SW_EXTRA;
	localparam int NW = $clog2(MAX_TERMS + 1);
	localparam int SH = RAD_SHIFT_BASE - FRAC_BITS;
	localparam int PRW = ANGLE_W + RAD_W + 1;
	localparam int TL = 6;
	localparam logic [PRW-1:0] RND = PRW'(1) << (SH - 1);
	localparam logic signed [SW-1:0] SAT_HI = SW'(SAT_HI_L);
	localparam logic signed [SW-1:0] SAT_LO = SW'(SAT_LO_L);

	typedef struct packed {
		logic          neg;
		logic [NW-1:0] n;
		logic [XW-1:0] x2;
	} side_t;

	logic [TERMS_W-1:0] num_terms_q;
	logic en;
	logic wr;

	// front end
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic neg_s1, neg_s2, neg_s3;
	logic [NW-1:0] n_s1, n_s2, n_s3, n_in;
	logic [ANGLE_W-1:0] mag_s1, raw_c;
	logic [PRW-1:0] prod_s2;
	logic [XMW-1:0] xm_s3, xm_s4;
	logic [2*XMW-1:0] sq_c;
	side_t side_s4;

	// term chain, entry k feeds term k+1
	side_t side_s [MAX_TERMS+1];
	logic side_vld_s [MAX_TERMS+1];
	side_t dly_s [MAX_TERMS][TL];
	logic dly_vld_s [MAX_TERMS][TL];
	logic [TW-1:0] ct_s [MAX_TERMS+1];
	logic [TW-1:0] st_s [MAX_TERMS+1];
	logic signed [SW-1:0] cs_s [MAX_TERMS+1];
	logic signed [SW-1:0] ss_s [MAX_TERMS+1];

	logic signed [SW-1:0] sin_c, cos_c;
	logic sin_hi, sin_lo, cos_hi, cos_lo;

	// configuration
	assign wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = APB_DW'(num_terms_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_terms_q <= NUM_TERMS_RST;
		end else if (wr && (paddr >> 2) == APB_AW'(REG_NUM_TERMS)) begin
			num_terms_q <= pwdata[TERMS_W-1:0];
		end
	end

	// advance everything unless the result register is held
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	assign raw_c = s_tdata[ANGLE_W-1:0];
	// clamp the term count to the built depth
	assign n_in = (32'(num_terms_q) > 32'(MAX_TERMS)) ? NW'(MAX_TERMS) : NW'(num_terms_q);
	assign sq_c = (2*XMW)'(xm_s3) * (2*XMW)'(xm_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// work on the magnitude, sign kept apart
			neg_s1 <= raw_c[ANGLE_W-1];
			mag_s1 <= raw_c[ANGLE_W-1] ? ANGLE_W'(0) - raw_c : raw_c;
			n_s1 <= n_in;
			prod_s2 <= PRW'(mag_s1) * PRW'(RAD_PER_DEG_Q40);
			neg_s2 <= neg_s1;
			n_s2 <= n_s1;
			xm_s3 <= XMW'((prod_s2 + RND) >> SH);
			neg_s3 <= neg_s2;
			n_s3 <= n_s2;
			xm_s4 <= xm_s3;
			side_s4.neg <= neg_s3;
			side_s4.n <= n_s3;
			side_s4.x2 <= XW'(sq_c >> FRAC_BITS);
		end
	end

	assign side_s[0] = side_s4;
	assign side_vld_s[0] = vld_s4;

	// leading terms: cos starts at one, sin at x
	assign ct_s[0] = TW'(1) << FRAC_BITS;
	assign cs_s[0] = SW'(1) << FRAC_BITS;
	assign st_s[0] = TW'(xm_s4);
	assign ss_s[0] = signed'(SW'(xm_s4));

	for (genvar k = 0; k < MAX_TERMS; k++) begin : g_term
		localparam int I = k + 1;
		logic use_c;
		logic sub_c;

		assign use_c = 32'(side_s[k].n) >= I;
		assign sub_c = I[0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int j = 0; j < TL; j++) begin
					dly_vld_s[k][j] <= 1'b0;
				end
			end else if (en) begin
				dly_vld_s[k][0] <= side_vld_s[k];
				for (int j = 1; j < TL; j++) begin
					dly_vld_s[k][j] <= dly_vld_s[k][j-1];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dly_s[k][0] <= side_s[k];
				for (int j = 1; j < TL; j++) begin
					dly_s[k][j] <= dly_s[k][j-1];
				end
			end
		end

		assign side_s[k+1] = dly_s[k][TL-1];
		assign side_vld_s[k+1] = dly_vld_s[k][TL-1];

		tsc_term #(.FRAC_BITS(FRAC_BITS), .DIV((2*I-1)*(2*I))) u_cos (
			.clk(clk), .en(en), .in_term(ct_s[k]), .in_sum(cs_s[k]),
			.x2(side_s[k].x2), .use_term(use_c), .sub_term(sub_c),
			.out_term(ct_s[k+1]), .out_sum(cs_s[k+1])
		);

		tsc_term #(.FRAC_BITS(FRAC_BITS), .DIV((2*I)*(2*I+1))) u_sin (
			.clk(clk), .en(en), .in_term(st_s[k]), .in_sum(ss_s[k]),
			.x2(side_s[k].x2), .use_term(use_c), .sub_term(sub_c),
			.out_term(st_s[k+1]), .out_sum(ss_s[k+1])
		);
	end

	// sign of sine follows the angle; clamp both to 32 bits
	assign sin_c = side_s[MAX_TERMS].neg ? -ss_s[MAX_TERMS] : ss_s[MAX_TERMS];
	assign cos_c = cs_s[MAX_TERMS];
	assign sin_hi = sin_c > SAT_HI;
	assign sin_lo = sin_c < SAT_LO;
	assign cos_hi = cos_c > SAT_HI;
	assign cos_lo = cos_c < SAT_LO;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= side_vld_s[MAX_TERMS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata[OUT_W-1:0] <= sin_hi ? OUT_W'(SAT_HI) :
				(sin_lo ? OUT_W'(SAT_LO) : sin_c[OUT_W-1:0]);
			m_tdata[2*OUT_W-1:OUT_W] <= cos_hi ? OUT_W'(SAT_HI) :
				(cos_lo ? OUT_W'(SAT_LO) : cos_c[OUT_W-1:0]);
			m_tuser[0] <= sin_hi || sin_lo || cos_hi || cos_lo;
		end
	end

	// a clip flag always comes with a result pinned at a limit
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			m_tdata[OUT_W-1:0] == OUT_W'(SAT_HI) || m_tdata[OUT_W-1:0] == OUT_W'(SAT_LO) ||
			m_tdata[2*OUT_W-1:OUT_W] == OUT_W'(SAT_HI) ||
			m_tdata[2*OUT_W-1:OUT_W] == OUT_W'(SAT_LO))
		else $error("clip flag without saturated result");

	// a register write reads back on the next cycle
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		wr |=> prdata[TERMS_W-1:0] == $past(pwdata[TERMS_W-1:0]))
		else $error("num_terms readback mismatch");

	// a held result is neither dropped nor altered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// no new transaction enters while the output is held
	a_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken during stall");
endmodule
`default_nettype wire

// File: dv/tb.sv
// Testbench for the Taylor sine/cosine core: directed angles, then random angles per term count.
`timescale 1ns / 100ps
module tb;
	import tsc_pkg::*;

	localparam int FRAC = 24;
	localparam int TERMS_MAX = 8;
	// covers the core pipeline depth at TERMS_MAX terms, with slack
	localparam int DRAIN_CYCLES = 70;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [63:0] RAD_Q40 = 64'd19190098069;

	typedef struct packed {
		logic [31:0] sine;
		logic [31:0] cosine;
		logic        clip;
	} trig_result_t;

	typedef struct {
		logic signed [ANGLE_W-1:0] angle;
		bit                        known;
		trig_result_t              res;
	} angle_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;
	logic s_tvalid, s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic m_tvalid, m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [0:0] m_tuser;

	trig_result_t pending_q[$];
	logic [TERMS_W-1:0] terms_reg;
	int send_idle_pct, recv_stall_pct;
	int cycles, errors;

	taylor_sine_cosine_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Series sum of sine and cosine, term by term, on magnitudes; sine sign applied last.
	function automatic trig_result_t taylor_eval(logic [ANGLE_W-1:0] raw, logic [TERMS_W-1:0] nt);
		trig_result_t r;
		logic [127:0] prod;
		logic [63:0] mag, xm, x2, tc, ts;
		longint cs, ss;
		int n;
		bit neg;
		neg = raw[ANGLE_W-1];
		mag = neg ? (64'd1 << ANGLE_W) - 64'(raw) : 64'(raw);
		xm = (mag * RAD_Q40 + (64'd1 << 22)) >> 23;
		x2 = (xm * xm) >> FRAC;
		n = (nt > TERMS_MAX) ? TERMS_MAX : int'(nt);
		tc = 64'd1 << FRAC;
		ts = xm;
		cs = longint'(tc);
		ss = longint'(xm);
		r.clip = 1'b0;
		for (int i = 1; i <= n; i++) begin
			prod = 128'(tc) * 128'(x2);
			tc = 64'(prod >> FRAC) / 64'((2*i - 1) * (2*i));
			prod = 128'(ts) * 128'(x2);
			ts = 64'(prod >> FRAC) / 64'((2*i) * (2*i + 1));
			if (i % 2) begin
				cs -= longint'(tc);
				ss -= longint'(ts);
			end else begin
				cs += longint'(tc);
				ss += longint'(ts);
			end
		end
		if (neg)
			ss = -ss;
		if (ss > SAT_HI_L) begin ss = SAT_HI_L; r.clip = 1'b1; end
		if (ss < SAT_LO_L) begin ss = SAT_LO_L; r.clip = 1'b1; end
		if (cs > SAT_HI_L) begin cs = SAT_HI_L; r.clip = 1'b1; end
		if (cs < SAT_LO_L) begin cs = SAT_LO_L; r.clip = 1'b1; end
		r.sine = ss[31:0];
		r.cosine = cs[31:0];
		return r;
	endfunction

	// Present one angle, idling at random first; queue the expectation on acceptance.
	task automatic send_angle(logic signed [ANGLE_W-1:0] a, bit known, trig_result_t typed);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W-ANGLE_W){1'b0}}, a};
		do @(posedge clk); while (!s_tready);
		pending_q.push_back(known ? typed : taylor_eval(a, terms_reg));
	endtask

	// Drop valid and hold until every result is back and the pipeline is empty.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write of num_terms: setup then access phase; junk in the unused upper bits.
	task automatic write_terms(logic [TERMS_W-1:0] v);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= APB_AW'(REG_NUM_TERMS * 4);
		pwdata <= {28'($urandom_range(32'h0fff_ffff)), v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		terms_reg = v;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
	endtask

	function automatic logic signed [ANGLE_W-1:0] rand_angle();
		// mostly the +/-360 degree range, sometimes the whole 17-bit field
		if ($urandom_range(9) == 0)
			return ANGLE_W'($urandom);
		return ANGLE_W'(int'($urandom_range(92160)) - 46080);
	endfunction

	// Receiver: stall at the current rate, change only at the falling edge.
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		trig_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result sine=%h cosine=%h clip=%b", $time,
					m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
			end else begin
				want = pending_q.pop_front();
				if (m_tdata[31:0] !== want.sine) begin
					errors++;
					$display("%0t: sine expected %h got %h", $time, want.sine, m_tdata[31:0]);
				end
				if (m_tdata[63:32] !== want.cosine) begin
					errors++;
					$display("%0t: cosine expected %h got %h", $time, want.cosine,
						m_tdata[63:32]);
				end
				if (m_tuser[0] !== want.clip) begin
					errors++;
					$display("%0t: clip expected %b got %b", $time, want.clip, m_tuser[0]);
				end
			end
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		angle_row_t rows[$];
		trig_result_t none;
		logic [TERMS_W-1:0] term_plan[$];
		int idle_plan[4][2];
		none = '0;
		cycles = 0;
		errors = 0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		s_tvalid = 1'b0; s_tdata = '0;
		send_idle_pct = 0; recv_stall_pct = 0;
		terms_reg = NUM_TERMS_RST;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: zero angle has exact answers; the rest are predicted.
		rows.push_back('{17'sd0, 1'b1, '{32'h0, 32'h0100_0000, 1'b0}});
		rows.push_back('{17'sd1, 1'b0, none});
		rows.push_back('{-17'sd1, 1'b0, none});
		rows.push_back('{17'sd11520, 1'b0, none});
		rows.push_back('{-17'sd11520, 1'b0, none});
		rows.push_back('{17'sd23040, 1'b0, none});
		rows.push_back('{-17'sd23040, 1'b0, none});
		rows.push_back('{17'sd34560, 1'b0, none});
		rows.push_back('{17'sd46080, 1'b0, none});
		rows.push_back('{-17'sd46080, 1'b0, none});
		rows.push_back('{17'sd65535, 1'b0, none});
		rows.push_back('{-17'sd65536, 1'b0, none});
		rows.push_back('{17'sd32767, 1'b0, none});
		rows.push_back('{-17'sd32768, 1'b0, none});
		rows.push_back('{17'sd21845, 1'b0, none});
		rows.push_back('{-17'sd43691, 1'b0, none});
		foreach (rows[i])
			send_angle(rows[i].angle, rows[i].known, rows[i].res);
		drain();

		// Random phases: each with its own term count and one of four idle patterns.
		term_plan = '{4'd0, 4'd8, 4'd15, 4'd1, 4'd9, 4'd3, 4'd6, 4'd2, 4'd5, 4'd7, 4'd4};
		idle_plan = '{'{0, 0}, '{85, 0}, '{0, 85}, '{12, 12}};
		foreach (term_plan[p]) begin
			write_terms(term_plan[p]);
			// with no terms the answer at zero is plain
			if (term_plan[p] == 4'd0)
				send_angle(17'sd0, 1'b1, '{32'h0, 32'h0100_0000, 1'b0});
			send_idle_pct = idle_plan[p % 4][0];
			recv_stall_pct = idle_plan[p % 4][1];
			for (int k = 0; k < 180; k++) begin
				// after 120 angles, switch to a no-idle stretch for the rest of the phase
				if (k == 120) begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				send_angle(rand_angle(), 1'b0, none);
			end
			drain();
		end

		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule

// File: sim.f
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_term.sv
hw/rtl/taylor_sine_cosine_core.sv
dv/tb.sv
